>>> sv/utf8_to_ascii_glyph_fold_top_macros.svh
// assertion macros for the utf8 to ascii glyph fold block
// expects clk_i and rst_ni in the scope of each use
`ifndef UTF8_TO_ASCII_GLYPH_FOLD_TOP_MACROS_SVH
`define UTF8_TO_ASCII_GLYPH_FOLD_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define U2A_ASSERT_IMPL(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |-> (conseq)) else $error(msg);

// next-cycle implication, disabled during reset
`define U2A_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (conseq)) else $error(msg);

`endif

>>> sv/u2a_pkg.sv
// shared types, constants and fold functions for the utf8 to ascii glyph fold block
// no dependencies
`default_nettype none

package u2a_pkg;

  localparam int QueueDepth = 4;

  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChX      = 8'h78;

  localparam logic [15:0] CpEnDash     = 16'h2013;
  localparam logic [15:0] CpEmDash     = 16'h2014;
  localparam logic [15:0] CpLsquo      = 16'h2018;
  localparam logic [15:0] CpRsquo      = 16'h2019;
  localparam logic [15:0] CpLdquo      = 16'h201C;
  localparam logic [15:0] CpRdquo      = 16'h201D;
  localparam logic [15:0] CpEllipsis   = 16'h2026;
  localparam logic [15:0] CpArrow      = 16'h2192;
  localparam logic [15:0] CpTimes      = 16'h00D7;
  localparam logic [15:0] CpMiddot     = 16'h00B7;
  localparam logic [15:0] CpBullet     = 16'h2022;
  localparam logic [15:0] CpPrintLo    = 16'h0021;
  localparam logic [15:0] CpPrintHi    = 16'h007E;

  localparam logic [2:0] LenNone  = 3'd1;
  localparam logic [2:0] LenTwo   = 3'd2;
  localparam logic [2:0] LenThree = 3'd3;
  localparam logic [2:0] LenFour  = 3'd4;

  // up to three output bytes caused by one input byte, first byte in slot 0
  typedef struct packed {
    logic [1:0]      n;
    logic [2:0][7:0] bytes;
  } pkt_t;

  typedef struct packed {
    logic valid;
    pkt_t pkt;
  } push_t;

  function automatic logic [2:0] seq_len(logic [7:0] c);
    logic [2:0] len;
    len = LenNone;
    if ((c & 8'hE0) == 8'hC0) len = LenTwo;
    else if ((c & 8'hF0) == 8'hE0) len = LenThree;
    else if ((c & 8'hF8) == 8'hF0) len = LenFour;
    return len;
  endfunction

  function automatic pkt_t pkt_none();
    pkt_t p;
    p.n     = 2'd0;
    p.bytes = '0;
    return p;
  endfunction

  function automatic pkt_t pkt_one(logic [7:0] a);
    pkt_t p;
    p          = pkt_none();
    p.n        = 2'd1;
    p.bytes[0] = a;
    return p;
  endfunction

  function automatic pkt_t pkt_two(logic [7:0] a, logic [7:0] b);
    pkt_t p;
    p          = pkt_one(a);
    p.n        = 2'd2;
    p.bytes[1] = b;
    return p;
  endfunction

  function automatic pkt_t fold_cp(logic [15:0] cp);
    pkt_t p;
    p = pkt_none();
    unique case (cp) inside
      CpEnDash, CpEmDash, CpMiddot, CpBullet: p = pkt_one(ChDash);
      CpLsquo, CpRsquo:                       p = pkt_one(ChQuote);
      CpLdquo, CpRdquo:                       p = pkt_one(ChDquote);
      CpTimes:                                p = pkt_one(ChX);
      CpArrow:                                p = pkt_two(ChDash, ChGt);
      CpEllipsis: begin
        p          = pkt_two(ChDot, ChDot);
        p.n        = 2'd3;
        p.bytes[2] = ChDot;
      end
      default: begin
        if (cp >= CpPrintLo && cp <= CpPrintHi) p = pkt_one(cp[7:0]);
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> sv/utf8_to_ascii_glyph_fold_top.sv
// top level of the utf8 to ascii glyph fold block
// depends on u2a_pkg, u2a_front, u2a_fifo and u2a_back
`default_nettype none

// Folds a utf8 byte stream to printable ascii lookalikes. An input beat is
// taken whenever the packet queue (QUEUE_DEPTH entries, default four) has
// room; each input beat yields zero to three output bytes, sent one per cycle
// by the output serializer while the output is ready, with tlast on the final
// byte of each input's results. Sustained rate is one input beat per cycle
// while the output is ready and averages at most one byte per input; otherwise
// the rate is set by the serializer draining the queue one byte each cycle.
module utf8_to_ascii_glyph_fold_top #(
  parameter int QUEUE_DEPTH = u2a_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic            m_axis_tlast_o    // out_run_last
);

  u2a_pkg::push_t push;
  u2a_pkg::pkt_t  head;
  logic           full, empty, pop;

  u2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .full_i     (full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push)
  );

  u2a_fifo #(
    .Depth (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  u2a_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .out_ready_i (m_axis_tready_i),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

>>> sv/u2a_front.sv
// front end: accepts input bytes, tracks the pending utf8 sequence, folds to packets
// depends on u2a_pkg
`default_nettype none

module u2a_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic [7:0]   in_byte_i,
  input  wire logic         in_last_i,
  input  wire logic         full_i,
  output logic              in_ready_o,
  output u2a_pkg::push_t    push_o
);

  logic [2:0][7:0] held_q;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      we;
  logic [2:0]      need;
  logic            accept, complete;
  logic [15:0]     cp2, cp3, cp_tail;
  u2a_pkg::pkt_t   pkt, fold_full;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  assign need     = u2a_pkg::seq_len(held_q[0]);
  assign complete = ({1'b0, cnt_q} + 3'd1) >= need;
  assign cp2      = {5'b0, held_q[0][4:0], in_byte_i[5:0]};
  assign cp3      = {held_q[0][3:0], held_q[1][5:0], in_byte_i[5:0]};
  assign cp_tail  = {5'b0, held_q[1][4:0], in_byte_i[5:0]};

  always_comb begin
    if (need == u2a_pkg::LenTwo) fold_full = u2a_pkg::fold_cp(cp2);
    else if (need == u2a_pkg::LenThree) fold_full = u2a_pkg::fold_cp(cp3);
    else fold_full = u2a_pkg::pkt_none();
  end

  always_comb begin
    pkt   = u2a_pkg::pkt_none();
    cnt_d = cnt_q;
    we    = 3'b000;
    if (cnt_q == 2'd0) begin
      if (!in_byte_i[7]) begin
        pkt = u2a_pkg::pkt_one(in_byte_i);
      end else if (!in_last_i && u2a_pkg::seq_len(in_byte_i) != u2a_pkg::LenNone) begin
        we[0] = 1'b1;
        cnt_d = 2'd1;
      end
    end else if (complete) begin
      pkt   = fold_full;
      cnt_d = 2'd0;
    end else if (!in_last_i) begin
      we[cnt_q] = 1'b1;
      cnt_d     = cnt_q + 2'd1;
    end else begin
      // truncated tail: lead dropped, rest scanned again
      cnt_d = 2'd0;
      if (cnt_q == 2'd1) begin
        if (!in_byte_i[7]) pkt = u2a_pkg::pkt_one(in_byte_i);
      end else if (!held_q[1][7]) begin
        if (!in_byte_i[7]) pkt = u2a_pkg::pkt_two(held_q[1], in_byte_i);
        else pkt = u2a_pkg::pkt_one(held_q[1]);
      end else if (u2a_pkg::seq_len(held_q[1]) == u2a_pkg::LenTwo) begin
        pkt = u2a_pkg::fold_cp(cp_tail);
      end else if (!in_byte_i[7]) begin
        pkt = u2a_pkg::pkt_one(in_byte_i);
      end
    end
  end

  assign push_o.valid = accept && (pkt.n != 2'd0);
  assign push_o.pkt   = pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && we[i]) held_q[i] <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

>>> sv/u2a_fifo.sv
// packet queue between the front end and the output serializer
// depends on u2a_pkg
`default_nettype none

module u2a_fifo #(
  parameter int Depth = u2a_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire u2a_pkg::push_t push_i,
  input  wire logic          pop_i,
  output logic               full_o,
  output logic               empty_o,
  output u2a_pkg::pkt_t      head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  u2a_pkg::pkt_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] bump(logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= bump(wptr_q);
      if (do_pop) rptr_q <= bump(rptr_q);
      if (do_push && !do_pop) cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_i.pkt;
  end

endmodule

`default_nettype wire

>>> sv/u2a_back.sv
// back end: serializes each queued packet one byte per beat, tlast on its final byte
// depends on u2a_pkg
`default_nettype none

module u2a_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire u2a_pkg::pkt_t head_i,
  input  wire logic          empty_i,
  input  wire logic          out_ready_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               out_last_o
);

  logic [1:0] idx_q;
  logic       beat;

  assign out_valid_o = !empty_i;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign out_last_o  = idx_q == (head_i.n - 2'd1);
  assign beat        = out_valid_o && out_ready_i;
  assign pop_o       = beat && out_last_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (beat) begin
      idx_q <= out_last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> sv/u2a_checker.sv
// port-level assertions for the utf8 to ascii glyph fold block, bound to the top level
// depends on utf8_to_ascii_glyph_fold_top_macros.svh and utf8_to_ascii_glyph_fold_top
`default_nettype none
`include "utf8_to_ascii_glyph_fold_top_macros.svh"

module u2a_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic [7:0] s_axis_tdata_i,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o
);

  `U2A_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o),
    "stalled output beat changed")
  `U2A_ASSERT_IMPL(a_out_ascii, m_axis_tvalid_o, !m_axis_tdata_o[7],
    "output byte outside ascii")
  `U2A_ASSERT_IMPL(a_stall_has_work, !s_axis_tready_o, m_axis_tvalid_o,
    "input stalled with nothing to send")
  `U2A_ASSERT_NEXT(a_run_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o,
    m_axis_tvalid_o, "run cut short before its last byte")

endmodule

bind utf8_to_ascii_glyph_fold_top u2a_checker u_u2a_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

`default_nettype wire

>>> test/tb.sv
// self-checking testbench for utf8_to_ascii_glyph_fold_top
// drives byte strings over the input stream and checks folded output beats
// depends on u2a_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fixed;
    logic [1:0] n;
    logic [7:0] r0;
  } dir_row_t;

  localparam int DirRows = 26;
  localparam int ExpDepth = 64;
  localparam dir_row_t DirTab [DirRows] = '{
    '{8'h00, 1'b0, 1'b1, 2'd1, 8'h00},
    '{8'h7F, 1'b0, 1'b1, 2'd1, 8'h7F},
    '{8'h80, 1'b0, 1'b1, 2'd0, 8'h00},
    '{8'hFF, 1'b0, 1'b1, 2'd0, 8'h00},
    '{8'hC3, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h97, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hC2, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hB7, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h94, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hA6, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h86, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h92, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hF0, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h9F, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h98, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h80, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hC1, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hA1, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'hE2, 1'b0, 1'b0, 2'd0, 8'h00},
    '{8'h41, 1'b1, 1'b0, 2'd0, 8'h00},
    '{8'h5A, 1'b1, 1'b0, 2'd0, 8'h00}
  };

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data = 8'h00;
  logic       s_last = 1'b0;
  logic       m_ready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;
  logic       m_axis_tlast_o;

  out_beat_t  exp_mem [ExpDepth];
  int         exp_wr = 0;
  int         exp_rd = 0;
  logic [7:0] str_buf [48];
  int         str_len = 0;
  logic [7:0] pend_bytes [3];
  int         pend_n = 0;
  logic [7:0] tail_buf [6];
  logic [7:0] fold_buf [3];
  int         fold_n = 0;
  int         fail_count = 0;
  int         in_idle_pct = 15;
  int         rx_count = 0;
  int         hold_left = 0;

  utf8_to_ascii_glyph_fold_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),     // [7:0] in_byte
    .s_axis_tlast_i  (s_last),     // in_last
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tlast_o  (m_axis_tlast_o)    // out_run_last
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int lead_len(logic [7:0] c);
    if (c[7:5] == 3'b110) return 2;
    if (c[7:4] == 4'b1110) return 3;
    if (c[7:3] == 5'b11110) return 4;
    return 1;
  endfunction

  function automatic logic [15:0] code_point(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, int len);
    if (len == 2) return {5'd0, b0[4:0], b1[5:0]};
    if (len == 3) return {b0[3:0], b1[5:0], b2[5:0]};
    return 16'd0;
  endfunction

  task automatic put_out(input logic [7:0] c);
    if (fold_n < 3) begin
      fold_buf[fold_n] = c;
      fold_n++;
    end
  endtask

  task automatic fold_point(input logic [15:0] cp);
    case (cp)
      u2a_pkg::CpEnDash, u2a_pkg::CpEmDash, u2a_pkg::CpMiddot, u2a_pkg::CpBullet:
        put_out(u2a_pkg::ChDash);
      u2a_pkg::CpLsquo, u2a_pkg::CpRsquo: put_out(u2a_pkg::ChQuote);
      u2a_pkg::CpLdquo, u2a_pkg::CpRdquo: put_out(u2a_pkg::ChDquote);
      u2a_pkg::CpTimes: put_out(u2a_pkg::ChX);
      u2a_pkg::CpArrow: begin
        put_out(u2a_pkg::ChDash);
        put_out(u2a_pkg::ChGt);
      end
      u2a_pkg::CpEllipsis: begin
        put_out(u2a_pkg::ChDot);
        put_out(u2a_pkg::ChDot);
        put_out(u2a_pkg::ChDot);
      end
      default: begin
        if (cp >= 16'h0021 && cp <= 16'h007E) put_out(cp[7:0]);
      end
    endcase
  endtask

  // rescan of held bytes plus the final byte at the end of a string
  task automatic scan_tail(input int n);
    int i;
    int len;
    i = 0;
    while (i < n) begin
      if (!tail_buf[i][7]) begin
        put_out(tail_buf[i]);
        i++;
      end else begin
        len = lead_len(tail_buf[i]);
        if (len > 1 && i + len - 1 < n) begin
          fold_point(code_point(tail_buf[i], tail_buf[i+1], tail_buf[i+2], len));
          i += len;
        end else begin
          i++;
        end
      end
    end
  endtask

  task automatic fold_byte(input logic [7:0] b, input logic l);
    int need;
    int k;
    fold_n = 0;
    if (l) begin
      for (k = 0; k < pend_n; k++) tail_buf[k] = pend_bytes[k];
      tail_buf[pend_n] = b;
      scan_tail(pend_n + 1);
      pend_n = 0;
    end else if (pend_n == 0) begin
      if (!b[7]) begin
        put_out(b);
      end else if (lead_len(b) > 1) begin
        pend_bytes[0] = b;
        pend_n = 1;
      end
    end else begin
      need = lead_len(pend_bytes[0]);
      if (pend_n + 1 >= need) begin
        for (k = 0; k < pend_n; k++) tail_buf[k] = pend_bytes[k];
        tail_buf[pend_n] = b;
        fold_point(code_point(tail_buf[0], tail_buf[1], tail_buf[2], need));
        pend_n = 0;
      end else begin
        pend_bytes[pend_n] = b;
        pend_n++;
      end
    end
  endtask

  task automatic add_expect(input logic [7:0] d, input logic l);
    exp_mem[exp_wr % ExpDepth] = '{d, l};
    exp_wr++;
  endtask

  task automatic push_folded();
    int k;
    for (k = 0; k < fold_n; k++) add_expect(fold_buf[k], k == fold_n - 1);
  endtask

  task automatic add_str_byte(input logic [7:0] b);
    str_buf[str_len] = b;
    str_len++;
  endtask

  task automatic offer_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // mostly well-formed characters, some noise, some strings cut short
  task automatic build_string();
    int chars;
    int pick;
    int cut;
    logic [23:0] g;
    str_len = 0;
    chars = $urandom_range(1, 10);
    repeat (chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        add_str_byte(8'($urandom_range(0, 127)));
      end else if (pick < 50) begin
        case ($urandom_range(0, 10))
          0: g = 24'hE28093;
          1: g = 24'hE28094;
          2: g = 24'hE28098;
          3: g = 24'hE28099;
          4: g = 24'hE2809C;
          5: g = 24'hE2809D;
          6: g = 24'hE280A6;
          7: g = 24'hE28692;
          8: g = 24'hE280A2;
          9: g = 24'hC39700;
          default: g = 24'hC2B700;
        endcase
        add_str_byte(g[23:16]);
        add_str_byte(g[15:8]);
        if (g[23:21] != 3'b110) add_str_byte(g[7:0]);
      end else if (pick < 60) begin
        add_str_byte({3'b110, 5'($urandom)});
        add_str_byte({2'b10, 6'($urandom)});
      end else if (pick < 70) begin
        add_str_byte({4'b1110, 4'($urandom)});
        add_str_byte({2'b10, 6'($urandom)});
        add_str_byte({2'b10, 6'($urandom)});
      end else if (pick < 77) begin
        add_str_byte({5'b11110, 3'($urandom)});
        repeat (3) add_str_byte({2'b10, 6'($urandom)});
      end else begin
        add_str_byte(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0 && str_len > 1) begin
      cut = $urandom_range(1, str_len > 2 ? 2 : 1);
      str_len -= cut;
    end
  endtask

  // output side: check each beat, random stalls, long holds to back up the block
  always @(posedge clk_i) begin
    out_beat_t w;
    if (rst_n && m_axis_tvalid_o && m_ready) begin
      if (exp_wr == exp_rd) begin
        $display("%0t: unexpected beat expected none actual data %h last %b", $time,
                 m_axis_tdata_o, m_axis_tlast_o);
        fail_count++;
      end else begin
        w = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (w.data !== m_axis_tdata_o) begin
          $display("%0t: out_byte expected %h actual %h", $time, w.data, m_axis_tdata_o);
          fail_count++;
        end
        if (w.last !== m_axis_tlast_o) begin
          $display("%0t: out_run_last expected %b actual %b", $time, w.last,
                   m_axis_tlast_o);
          fail_count++;
        end
      end
      rx_count++;
      if (rx_count == 40 || rx_count == 250) hold_left = 150;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (rx_count >= 300 && rx_count < 420) begin
      m_ready <= 1'b1;
    end else begin
      m_ready <= ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin : main
    int i;
    int k;
    int sent;
    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DirRows; i++) begin
      fold_byte(DirTab[i].data, DirTab[i].last);
      if (DirTab[i].fixed) begin
        if (DirTab[i].n != 2'd0) add_expect(DirTab[i].r0, 1'b1);
      end else begin
        push_folded();
      end
      offer_beat(DirTab[i].data, DirTab[i].last);
    end

    sent = 0;
    while (sent < 430) begin
      build_string();
      for (k = 0; k < str_len; k++) begin
        in_idle_pct = (sent >= 150 && sent < 250) ? 0 : 15;
        fold_byte(str_buf[k], k == str_len - 1);
        push_folded();
        offer_beat(str_buf[k], k == str_len - 1);
        sent++;
      end
    end
    s_valid <= 1'b0;

    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && exp_wr == exp_rd) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> utf8_to_ascii_glyph_fold_top.f
+incdir+sv
sv/u2a_pkg.sv
sv/u2a_front.sv
sv/u2a_fifo.sv
sv/u2a_back.sv
sv/utf8_to_ascii_glyph_fold_top.sv
sv/u2a_checker.sv
test/tb.sv
